@@ hw/rtl/h2rcp_pkg.sv @@
// Shared types and constants for the HSV to RGB colour packer pipeline.
`timescale 1ns / 1ps
`default_nettype none
package h2rcp_pkg;

	localparam logic [7:0]  FULL_LEVEL   = 8'd255;
	localparam logic [15:0] FULL_SQUARE  = 16'd65025;
	// floor(2^16 / 255) and floor(2^32 / 65025)
	localparam logic [8:0]  RECIP_LEVEL  = 9'd257;
	localparam logic [16:0] RECIP_SQUARE = 17'd66051;

	typedef enum logic [2:0] {
		SECT_RED_YEL  = 3'd0,
		SECT_YEL_GRN  = 3'd1,
		SECT_GRN_CYN  = 3'd2,
		SECT_CYN_BLU  = 3'd3,
		SECT_BLU_MAG  = 3'd4,
		SECT_MAG_RED  = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t     sector;
		logic [7:0]  bri;
		logic [7:0]  sat_inv;
		logic [15:0] frac_sat;
		logic [15:0] rfrac_sat;
	} s1_t;

	typedef struct packed {
		sector_t     sector;
		logic [7:0]  bri;
		logic [15:0] num_p;
		logic [23:0] num_q;
		logic [23:0] num_t;
	} s2_t;

	typedef struct packed {
		sector_t     sector;
		logic [7:0]  bri;
		logic [15:0] num_p;
		logic [23:0] num_q;
		logic [23:0] num_t;
		logic [7:0]  est_p;
		logic [7:0]  est_q;
		logic [7:0]  est_t;
	} s3_t;

	typedef struct packed {
		sector_t     sector;
		logic [7:0]  bri;
		logic [7:0]  lvl_p;
		logic [7:0]  lvl_q;
		logic [7:0]  lvl_t;
	} s4_t;

endpackage
`default_nettype wire

@@ hw/rtl/hsv_to_rgb_color_packer_top.sv @@
// Top level of the HSV to RGB colour packer: pipeline stages and output channel selection.
// Throughput: one beat per cycle; the five register stages stall together while
// the output beat waits, and a new beat enters whenever the last stage is empty or draining.
// Reset clears the stage valid bits only; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module hsv_to_rgb_color_packer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pix_valid,
	output logic             pix_ready,
	input  wire logic [7:0]  hue,
	input  wire logic [7:0]  saturation,
	input  wire logic [7:0]  brightness,
	output logic             rgb_valid,
	input  wire logic        rgb_ready,
	output logic [7:0]       red_level,
	output logic [7:0]       green_level,
	output logic [7:0]       blue_level,
	output logic [23:0]      packed_color
);
	import h2rcp_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s4;
	s1_t        data_s1;
	s2_t        data_s2;
	s4_t        data_s4;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	assign advance   = !rgb_valid || rgb_ready;
	assign pix_ready = advance;

	h2rcp_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.valid_in   (pix_valid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	h2rcp_product u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	h2rcp_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	always_comb begin
		case (data_s4.sector)
			SECT_RED_YEL: begin
				red = data_s4.bri;   green = data_s4.lvl_t; blue = data_s4.lvl_p;
			end
			SECT_YEL_GRN: begin
				red = data_s4.lvl_q; green = data_s4.bri;   blue = data_s4.lvl_p;
			end
			SECT_GRN_CYN: begin
				red = data_s4.lvl_p; green = data_s4.bri;   blue = data_s4.lvl_t;
			end
			SECT_CYN_BLU: begin
				red = data_s4.lvl_p; green = data_s4.lvl_q; blue = data_s4.bri;
			end
			SECT_BLU_MAG: begin
				red = data_s4.lvl_t; green = data_s4.lvl_p; blue = data_s4.bri;
			end
			default: begin
				red = data_s4.bri;   green = data_s4.lvl_p; blue = data_s4.lvl_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid <= 1'b0;
		end else if (advance) begin
			rgb_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_level    <= red;
			green_level  <= green;
			blue_level   <= blue;
			packed_color <= {green, red, blue};
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/h2rcp_sector.sv @@
// Stage 1: hue sector and fraction, saturation products.
`timescale 1ns / 1ps
`default_nettype none
module h2rcp_sector (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          valid_in,
	input  wire logic [7:0]    hue,
	input  wire logic [7:0]    saturation,
	input  wire logic [7:0]    brightness,
	output logic               valid_s1,
	output h2rcp_pkg::s1_t     data_s1
);
	import h2rcp_pkg::*;

	logic [10:0] h6;
	logic [10:0] base;
	sector_t     sector;
	logic [7:0]  frac;
	logic [7:0]  rfrac;
	s1_t         next;

	always_comb begin
		h6 = 11'(hue) * 11'd6;
		if (h6 >= 11'(FULL_LEVEL) * 11'd6) begin
			// full-scale hue wraps to the first sector
			sector = SECT_RED_YEL;
			base   = 11'(FULL_LEVEL) * 11'd6;
		end else if (h6 >= 11'(FULL_LEVEL) * 11'd5) begin
			sector = SECT_MAG_RED;
			base   = 11'(FULL_LEVEL) * 11'd5;
		end else if (h6 >= 11'(FULL_LEVEL) * 11'd4) begin
			sector = SECT_BLU_MAG;
			base   = 11'(FULL_LEVEL) * 11'd4;
		end else if (h6 >= 11'(FULL_LEVEL) * 11'd3) begin
			sector = SECT_CYN_BLU;
			base   = 11'(FULL_LEVEL) * 11'd3;
		end else if (h6 >= 11'(FULL_LEVEL) * 11'd2) begin
			sector = SECT_GRN_CYN;
			base   = 11'(FULL_LEVEL) * 11'd2;
		end else if (h6 >= 11'(FULL_LEVEL)) begin
			sector = SECT_YEL_GRN;
			base   = 11'(FULL_LEVEL);
		end else begin
			sector = SECT_RED_YEL;
			base   = 11'd0;
		end
		frac  = 8'(h6 - base);
		rfrac = FULL_LEVEL - frac;
		next.sector    = sector;
		next.bri       = brightness;
		next.sat_inv   = FULL_LEVEL - saturation;
		next.frac_sat  = 16'(frac) * 16'(saturation);
		next.rfrac_sat = 16'(rfrac) * 16'(saturation);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= next;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/h2rcp_product.sv @@
// Stage 2: brightness products, the numerators of p, q and t.
`timescale 1ns / 1ps
`default_nettype none
module h2rcp_product (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          valid_s1,
	input  wire h2rcp_pkg::s1_t data_s1,
	output logic               valid_s2,
	output h2rcp_pkg::s2_t     data_s2
);
	import h2rcp_pkg::*;

	s2_t next;

	always_comb begin
		next.sector = data_s1.sector;
		next.bri    = data_s1.bri;
		next.num_p  = 16'(data_s1.bri) * 16'(data_s1.sat_inv);
		next.num_q  = 24'(data_s1.bri) * 24'(FULL_SQUARE - data_s1.frac_sat);
		next.num_t  = 24'(data_s1.bri) * 24'(FULL_SQUARE - data_s1.rfrac_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= next;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/h2rcp_divide.sv @@
// Stages 3 and 4: constant division by reciprocal multiply and one-step correction.
`timescale 1ns / 1ps
`default_nettype none
module h2rcp_divide (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          valid_s2,
	input  wire h2rcp_pkg::s2_t data_s2,
	output logic               valid_s4,
	output h2rcp_pkg::s4_t     data_s4
);
	import h2rcp_pkg::*;

	logic        valid_s3;
	s3_t         data_s3;
	s3_t         next3;
	s4_t         next4;
	logic [24:0] prod_p;
	logic [40:0] prod_q;
	logic [40:0] prod_t;
	logic [8:0]  inc_p;
	logic [8:0]  inc_q;
	logic [8:0]  inc_t;
	logic [16:0] lim_p;
	logic [24:0] lim_q;
	logic [24:0] lim_t;

	// estimates undershoot by at most one
	always_comb begin
		prod_p = 25'(data_s2.num_p) * 25'(RECIP_LEVEL);
		prod_q = 41'(data_s2.num_q) * 41'(RECIP_SQUARE);
		prod_t = 41'(data_s2.num_t) * 41'(RECIP_SQUARE);
		next3.sector = data_s2.sector;
		next3.bri    = data_s2.bri;
		next3.num_p  = data_s2.num_p;
		next3.num_q  = data_s2.num_q;
		next3.num_t  = data_s2.num_t;
		next3.est_p  = prod_p[23:16];
		next3.est_q  = prod_q[39:32];
		next3.est_t  = prod_t[39:32];
	end

	// (e+1)*255 = (e+1)<<8 - (e+1); (e+1)*65025 = (e+1)<<16 - (e+1)<<9 + (e+1)
	always_comb begin
		inc_p = 9'(data_s3.est_p) + 9'd1;
		inc_q = 9'(data_s3.est_q) + 9'd1;
		inc_t = 9'(data_s3.est_t) + 9'd1;
		lim_p = {inc_p, 8'd0} - 17'(inc_p);
		lim_q = {inc_q, 16'd0} - 25'({inc_q, 9'd0}) + 25'(inc_q);
		lim_t = {inc_t, 16'd0} - 25'({inc_t, 9'd0}) + 25'(inc_t);
		next4.sector = data_s3.sector;
		next4.bri    = data_s3.bri;
		next4.lvl_p  = (17'(data_s3.num_p) >= lim_p) ? inc_p[7:0] : data_s3.est_p;
		next4.lvl_q  = (25'(data_s3.num_q) >= lim_q) ? inc_q[7:0] : data_s3.est_q;
		next4.lvl_t  = (25'(data_s3.num_t) >= lim_t) ? inc_t[7:0] : data_s3.est_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s3 <= next3;
			data_s4 <= next4;
		end
	end

endmodule
`default_nettype wire
